### design/led_activity_heartbeat_blinker_unit_assert.svh
// Assertion macros for the LED blinker unit.
// Used by the port checker; depends on clk_i and rst_ni in the including scope.
`ifndef LED_ACTIVITY_HEARTBEAT_BLINKER_UNIT_ASSERT_SVH
`define LED_ACTIVITY_HEARTBEAT_BLINKER_UNIT_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define LHB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define LHB_ASSERT_NEXT(label, ante, cons, msg) \
  `LHB_ASSERT(label, (ante) |=> (cons), msg)

`endif

### design/lhb_pkg.sv
// Shared types and constants for the LED activity/heartbeat blinker.
// No dependencies.
`default_nettype none

package lhb_pkg;

  typedef enum logic [1:0] {
    MODE_HOLD      = 2'd0,
    MODE_STATUS    = 2'd1,
    MODE_HEARTBEAT = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE         = 3'd0,
    CFG_STAT_OFF_MAX = 3'd1,
    CFG_STAT_ON_MIN  = 3'd2,
    CFG_STAT_LIMIT   = 3'd3,
    CFG_BEAT_ON      = 3'd4,
    CFG_BEAT_OFF     = 3'd5,
    CFG_BEAT_REST    = 3'd6
  } cfg_idx_e;

  // Item kinds carried in tuser
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned OUT_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [COUNT_W-1:0] PHASE_FIRST = 8'd0;
  localparam logic [COUNT_W-1:0] PHASE_HIGH1 = 8'd1;
  localparam logic [COUNT_W-1:0] PHASE_LOW2  = 8'd2;
  localparam logic [COUNT_W-1:0] PHASE_REST  = 8'd3;

  typedef struct packed {
    mode_e              mode;
    logic [THR_W-1:0]   stat_off_max;
    logic [THR_W-1:0]   stat_on_min;
    logic [COUNT_W-1:0] stat_limit;
    logic [THR_W-1:0]   beat_on;
    logic [THR_W-1:0]   beat_off;
    logic [THR_W-1:0]   beat_rest;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:         MODE_STATUS,
    stat_off_max: 16'd100,
    stat_on_min:  16'd50,
    stat_limit:   8'd10,
    beat_on:      16'd100,
    beat_off:     16'd100,
    beat_rest:    16'd1000
  };

endpackage

`default_nettype wire

### design/lhb_cfg_regs.sv
// Configuration register bank for the LED blinker.
// Depends on lhb_pkg.
`default_nettype none

module lhb_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lhb_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [lhb_pkg::CFG_W-1:0] cfg_wdata_i,
  output lhb_pkg::cfg_t                  cfg_o
);
  import lhb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:         cfg_d.mode         = mode_e'(cfg_wdata_i[1:0]);
        CFG_STAT_OFF_MAX: cfg_d.stat_off_max = cfg_wdata_i;
        CFG_STAT_ON_MIN:  cfg_d.stat_on_min  = cfg_wdata_i;
        CFG_STAT_LIMIT:   cfg_d.stat_limit   = cfg_wdata_i[COUNT_W-1:0];
        CFG_BEAT_ON:      cfg_d.beat_on      = cfg_wdata_i;
        CFG_BEAT_OFF:     cfg_d.beat_off     = cfg_wdata_i;
        CFG_BEAT_REST:    cfg_d.beat_rest    = cfg_wdata_i;
        default:          cfg_d = cfg_q; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/lhb_core.sv
// Pin state and next-state logic for one tick or activity item.
// Depends on lhb_pkg.
`default_nettype none

module lhb_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  lhb_pkg::cfg_t                   cfg_i,
  input  wire logic                       step_i,
  input  wire logic                       func_i,
  input  wire logic [lhb_pkg::TIME_W-1:0] now_i,
  output logic                            pin_d_o
);
  import lhb_pkg::*;

  logic               pin_q, pin_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [TIME_W-1:0]  elapsed;
  logic               off_max_hit, on_min_hit, beat_on_hit, beat_off_hit, beat_rest_hit;

  assign elapsed       = now_i - start_q;
  assign off_max_hit   = elapsed >= {{(TIME_W-THR_W){1'b0}}, cfg_i.stat_off_max};
  assign on_min_hit    = elapsed >= {{(TIME_W-THR_W){1'b0}}, cfg_i.stat_on_min};
  assign beat_on_hit   = elapsed >= {{(TIME_W-THR_W){1'b0}}, cfg_i.beat_on};
  assign beat_off_hit  = elapsed >= {{(TIME_W-THR_W){1'b0}}, cfg_i.beat_off};
  assign beat_rest_hit = elapsed >= {{(TIME_W-THR_W){1'b0}}, cfg_i.beat_rest};

  always_comb begin
    pin_d   = pin_q;
    start_d = start_q;
    count_d = count_q;
    if (func_i == FUNC_EVENT) begin
      if (cfg_i.mode == MODE_STATUS && count_q != COUNT_MAX) begin
        count_d = count_q + COUNT_W'(1);
      end
    end else begin
      case (cfg_i.mode)
        MODE_STATUS: begin
          if (pin_q) begin
            if (off_max_hit) begin
              pin_d   = 1'b0;
              start_d = now_i;
              count_d = '0;
            end
          end else if (count_q > cfg_i.stat_limit && on_min_hit) begin
            pin_d   = 1'b1;
            start_d = now_i;
            count_d = '0;
          end
        end
        MODE_HEARTBEAT: begin
          // a stale status count above the last beat phase acts as the rest phase
          if (count_q > PHASE_LOW2) begin
            if (beat_rest_hit) begin
              pin_d   = 1'b0;
              start_d = now_i;
              count_d = PHASE_FIRST;
            end
          end else if (count_q == PHASE_FIRST || count_q == PHASE_LOW2) begin
            if (beat_on_hit) begin
              pin_d   = 1'b1;
              start_d = now_i;
              count_d = (count_q == PHASE_FIRST) ? PHASE_HIGH1 : PHASE_REST;
            end
          end else if (beat_off_hit) begin
            pin_d   = 1'b0;
            start_d = now_i;
            count_d = PHASE_LOW2;
          end
        end
        default: ; // hold
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q   <= 1'b1;
      start_q <= '0;
      count_q <= '0;
    end else if (step_i) begin
      pin_q   <= pin_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  assign pin_d_o = pin_d;

endmodule

`default_nettype wire

### design/led_activity_heartbeat_blinker_unit.sv
// LED activity/heartbeat blinker. Takes one item (tick or activity event) per
// cycle while tready is high and returns the pin level after that item: the
// item waits in the input register, then the pin state updates and the level
// is captured in the result register. Throughput is one item per clock while
// tready is high; tready drops only while both the input and result registers
// are full and the result is not taken. Depends on lhb_pkg, lhb_cfg_regs, lhb_core.
`default_nettype none

module led_activity_heartbeat_blinker_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write port
  input  wire logic                      cfg_we_i,
  input  wire logic [lhb_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [lhb_pkg::CFG_W-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // [31:0] now_time
  input  wire logic                      s_axis_tuser,  // [0] func
  // result stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [lhb_pkg::OUT_W-1:0]      m_axis_tdata   // [0] pin_high, [7:1] zero
);
  import lhb_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q, in_valid_d;
  logic              in_func_q;
  logic [TIME_W-1:0] in_time_q;
  logic              out_valid_q, out_valid_d;
  logic              out_pin_q;
  logic              advance, accept, pin_next;

  lhb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // move the held item into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lhb_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (advance),
    .func_i  (in_func_q),
    .now_i   (in_time_q),
    .pin_d_o (pin_next)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_func_q <= s_axis_tuser;
      in_time_q <= s_axis_tdata;
    end
    if (advance) begin
      out_pin_q <= pin_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, out_pin_q};

endmodule

`default_nettype wire

### design/lhb_checker.sv
// Port-level checker for the LED blinker unit, bound to the top level.
// Depends on lhb_pkg and the assertion macro header.
`default_nettype none

`include "led_activity_heartbeat_blinker_unit_assert.svh"

module lhb_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic [lhb_pkg::OUT_W-1:0] m_axis_tdata
);

  // a stalled result holds
  `LHB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // padding bits above the pin level stay zero
  `LHB_ASSERT(a_pad_zero, !m_axis_tvalid || m_axis_tdata[lhb_pkg::OUT_W-1:1] == '0, "result padding not zero")

  // input backpressure only while a result waits untaken
  `LHB_ASSERT(a_ready_cause, s_axis_tready || (m_axis_tvalid && !m_axis_tready), "tready low without output stall")

  // a new result traces back to an earlier accepted input transfer
  `LHB_ASSERT(a_out_source, !$rose(m_axis_tvalid) || $past(s_axis_tvalid && s_axis_tready, 2), "result without transfer")

endmodule

bind led_activity_heartbeat_blinker_unit lhb_checker u_lhb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
